// ===== rtl/core/half_period_rms_meter_core_defines.svh =====
// ----------------------------------------------------------------------------
// half_period_rms_meter_core_defines.svh
// Assertion macros used by the RMS meter checker.
// ----------------------------------------------------------------------------
`ifndef HALF_PERIOD_RMS_METER_CORE_DEFINES_SVH
`define HALF_PERIOD_RMS_METER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define HPRM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define HPRM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/hprm_pkg.sv =====
// ----------------------------------------------------------------------------
// hprm_pkg
// Types and fixed constants of the half-period RMS meter.
// ----------------------------------------------------------------------------
`default_nettype none

package hprm_pkg;

    // Field and datapath widths
    localparam int RATE_W   = 20;
    localparam int FREQ_W   = 20;
    localparam int RMS_W    = 16;
    localparam int SUM_W    = 64;
    localparam int CNT_W    = 32;
    localparam int MUL_W    = 32;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int LIMIT_W  = 30;               // 1000 * (2^20 - 1) < 2^30
    localparam int PART_W   = MUL_W + FREQ_W;   // one partial product of sum * freq
    localparam int NUM_W    = SUM_W + FREQ_W;   // full numerator sum * freq
    localparam int QUO_W    = 32;               // quotient kept for the root
    localparam int CSUB_W   = QUO_W + 1;
    localparam int STEP_W   = 5;

    // Fixed values
    localparam int                LIMIT_SCALE = 1000;
    localparam logic [RATE_W-1:0] RATE_RESET  = RATE_W'(10000);
    localparam logic [RMS_W-1:0]  RMS_MAX     = '1;
    localparam int                DIV_STEPS   = QUO_W;
    localparam int                SQRT_STEPS  = QUO_W / 2;
    localparam logic [QUO_W-1:0]  SQRT_BIT0   = QUO_W'(1) << (QUO_W - 2);

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_LIM,
        S_CNT,
        S_CMP,
        S_PL,
        S_PH,
        S_SAT,
        S_DIV,
        S_SQRT,
        S_FIN,
        S_DONE
    } t_state;

    // Operand selection of the shared multiplier
    typedef enum logic [2:0] {
        MS_SQ,
        MS_LIM,
        MS_CNT,
        MS_SLO,
        MS_SHI
    } t_mul_sel;

    // Sequencer to datapath
    typedef struct packed {
        logic     idle;
        t_mul_sel mul_sel;
        logic     ld_term;
        logic     ld_sum;
        logic     chk_close;
        logic     ld_plo;
        logic     ld_phi;
        logic     chk_sat;
        logic     div_step;
        logic     sqrt_step;
        logic     fin;
        logic     emit;
    } t_ctl;

    // Datapath to sequencer
    typedef struct packed {
        logic in_acc;
        logic close;
        logic sat;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/core/hprm_mul.sv =====
// ----------------------------------------------------------------------------
// hprm_mul
// Shared 32x32 multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module hprm_mul (
    input  wire logic                       i_clk,
    input  wire logic [hprm_pkg::MUL_W-1:0] i_a,
    input  wire logic [hprm_pkg::MUL_W-1:0] i_b,
    output logic [hprm_pkg::PROD_W-1:0]     o_prod
);
    import hprm_pkg::*;

    logic [PROD_W-1:0] r_prod;

    // Register every product; the sequencer picks it up in the following cycle
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ===== rtl/core/hprm_csub.sv =====
// ----------------------------------------------------------------------------
// hprm_csub
// Shared compare-and-subtract unit for division and square root steps.
// ----------------------------------------------------------------------------
`default_nettype none

module hprm_csub (
    input  wire logic [hprm_pkg::CSUB_W-1:0] i_a,
    input  wire logic [hprm_pkg::CSUB_W-1:0] i_b,
    output logic                             o_ge,
    output logic [hprm_pkg::CSUB_W-1:0]      o_diff
);
    import hprm_pkg::*;

    logic [CSUB_W:0] wide_diff;

    // One subtract; the borrow gives the compare
    assign wide_diff = {1'b0, i_a} - {1'b0, i_b};
    assign o_ge      = ~wide_diff[CSUB_W];
    assign o_diff    = wide_diff[CSUB_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/hprm_seq.sv =====
// ----------------------------------------------------------------------------
// hprm_seq
// Sequencer: steps one request through the shared multiplier and the
// compare-subtract unit.
// ----------------------------------------------------------------------------
`default_nettype none

module hprm_seq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire hprm_pkg::t_sts i_sts,
    output hprm_pkg::t_ctl     o_ctl
);
    import hprm_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic [STEP_W-1:0]  r_step;
    logic [STEP_W-1:0]  n_step;
    logic               step_last;

    assign step_last = (r_step == '0);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_sts.in_acc) begin
                    n_state = S_SQ;
                end
            end
            S_SQ:   n_state = S_LIM;
            S_LIM:  n_state = S_CNT;
            S_CNT:  n_state = S_CMP;
            S_CMP:  n_state = i_sts.close ? S_PL : S_DONE;
            S_PL:   n_state = S_PH;
            S_PH:   n_state = S_SAT;
            S_SAT:  n_state = i_sts.sat ? S_FIN : S_DIV;
            S_DIV: begin
                if (step_last) begin
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (step_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN:  n_state = S_DONE;
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Step counter for the iterative phases
    always_comb begin
        n_step = r_step;
        priority if (r_state == S_SAT) begin
            n_step = STEP_W'(DIV_STEPS - 1);
        end else if (r_state == S_DIV && step_last) begin
            n_step = STEP_W'(SQRT_STEPS - 1);
        end else if (r_state == S_DIV || r_state == S_SQRT) begin
            n_step = r_step - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Outputs decoded from the state
    always_comb begin
        o_ctl           = '0;
        o_ctl.mul_sel   = MS_SQ;
        unique case (r_state)
            S_IDLE: o_ctl.idle = 1'b1;
            S_SQ:   o_ctl.mul_sel = MS_SQ;
            S_LIM: begin
                o_ctl.mul_sel = MS_LIM;
                o_ctl.ld_term = 1'b1;
            end
            S_CNT: begin
                o_ctl.mul_sel = MS_CNT;
                o_ctl.ld_sum  = 1'b1;
            end
            S_CMP: begin
                o_ctl.mul_sel   = MS_SLO;
                o_ctl.chk_close = 1'b1;
            end
            S_PL: begin
                o_ctl.mul_sel = MS_SHI;
                o_ctl.ld_plo  = 1'b1;
            end
            S_PH:   o_ctl.ld_phi    = 1'b1;
            S_SAT:  o_ctl.chk_sat   = 1'b1;
            S_DIV:  o_ctl.div_step  = 1'b1;
            S_SQRT: o_ctl.sqrt_step = 1'b1;
            S_FIN:  o_ctl.fin       = 1'b1;
            S_DONE: o_ctl.emit      = i_sts.out_free;
            default: o_ctl.idle     = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/half_period_rms_meter_core.sv =====
// ----------------------------------------------------------------------------
// half_period_rms_meter_core
// Half-period RMS meter: trapezoid sum of squares over a window of half the
// signal period, then floor(sqrt(freq * sum / (1000 * rate))) per window.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  in        sink       i_in_valid / o_in_stall  i_sample, i_freq_mhz
//  out       source     o_out_valid / i_out_stall o_rms_value, o_new_value
//  cfg       sink       i_cfg_valid / o_cfg_ready i_cfg_data (sample_rate_hz)
//
//  A request is worked on to its end before the next one is accepted; the
//  block is ready again in the cycle in which its result appears. The work
//  runs through the shared multiplier (up to five products per request) and,
//  when a window closes and the root does not saturate, through the
//  compare-subtract unit: 32 division steps, then 16 square root steps.
//  Reset is synchronous and active low; it clears the sum, count, held value
//  and sets the rate to 10000. A stalled result is held in the output
//  register while the next request is accepted and worked on. An offered
//  rate write stalls the input for that cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module half_period_rms_meter_core #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input requests
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0]    i_sample,
    input  wire logic [hprm_pkg::FREQ_W-1:0]       i_freq_mhz,
    // results
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [hprm_pkg::RMS_W-1:0]             o_rms_value,
    output logic                                   o_new_value,
    // rate register
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [hprm_pkg::RATE_W-1:0]       i_cfg_data
);
    import hprm_pkg::*;

    t_ctl ctl;
    t_sts sts;

    // Architectural state
    logic [RATE_W-1:0]       r_rate;
    logic [SUM_W-1:0]        r_prev_sq;
    logic [SUM_W-1:0]        r_sum;
    logic [CNT_W-1:0]        r_count;
    logic [RMS_W-1:0]        r_held;
    logic                    r_out_valid;
    logic [RMS_W-1:0]        r_out_rms;
    logic                    r_out_new;

    // Working registers of one request
    logic [SAMPLE_WIDTH-1:0] r_mag;
    logic [FREQ_W-1:0]       r_freq;
    logic [SUM_W-1:0]        r_term;
    logic [LIMIT_W-1:0]      r_limit;
    logic                    r_new;
    logic [NUM_W-1:0]        r_num;
    logic [LIMIT_W-1:0]      r_rem;
    logic [QUO_W-1:0]        r_quo;
    logic [QUO_W-1:0]        r_res;
    logic [QUO_W-1:0]        r_bit;

    logic                    in_acc;
    logic                    out_acc;
    logic [SAMPLE_WIDTH-1:0] mag_in;
    logic [RATE_W-1:0]       rate_eff;
    logic [MUL_W-1:0]        mul_a;
    logic [MUL_W-1:0]        mul_b;
    logic [PROD_W-1:0]       prod;
    logic [SUM_W:0]          sum_add;
    logic [CSUB_W-1:0]       csub_a;
    logic [CSUB_W-1:0]       csub_b;
    logic                    csub_ge;
    logic [CSUB_W-1:0]       csub_diff;
    logic [PART_W-1:0]       num_hi_add;

    // Handshakes; a rate write goes ahead of a request
    assign in_acc      = i_in_valid & ~o_in_stall;
    assign out_acc     = r_out_valid & ~i_out_stall;
    assign o_in_stall  = ~ctl.idle | i_cfg_valid;
    assign o_cfg_ready = ctl.idle;

    assign sts.in_acc   = in_acc;
    assign sts.close    = {prod[PART_W-1:0], 1'b0} >= (PART_W + 1)'(r_limit);
    assign sts.sat      = r_num[NUM_W-1:QUO_W] >= PART_W'(r_limit);
    assign sts.out_free = ~r_out_valid | ~i_out_stall;

    // Magnitude of the two's complement sample
    assign mag_in = i_sample[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-$unsigned(i_sample))
                                             : SAMPLE_WIDTH'($unsigned(i_sample));

    // A zero rate acts as one
    assign rate_eff = (r_rate == '0) ? RATE_W'(1) : r_rate;

    // Multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (ctl.mul_sel)
            MS_SQ: begin
                mul_a = MUL_W'(r_mag);
                mul_b = MUL_W'(r_mag);
            end
            MS_LIM: begin
                mul_a = MUL_W'(rate_eff);
                mul_b = MUL_W'(LIMIT_SCALE);
            end
            MS_CNT: begin
                mul_a = r_count;
                mul_b = MUL_W'(r_freq);
            end
            MS_SLO: begin
                mul_a = r_sum[MUL_W-1:0];
                mul_b = MUL_W'(r_freq);
            end
            MS_SHI: begin
                mul_a = r_sum[SUM_W-1:MUL_W];
                mul_b = MUL_W'(r_freq);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    hprm_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // Compare-subtract operands: a division step or a root step
    assign csub_a = ctl.sqrt_step ? {1'b0, r_quo} : {2'b00, r_rem, r_quo[QUO_W-1]};
    assign csub_b = ctl.sqrt_step ? {1'b0, r_res | r_bit} : {3'b000, r_limit};

    hprm_csub u_csub (
        .i_a    (csub_a),
        .i_b    (csub_b),
        .o_ge   (csub_ge),
        .o_diff (csub_diff)
    );

    assign sum_add    = {1'b0, r_sum} + {1'b0, r_term};
    assign num_hi_add = prod[PART_W-1:0] + r_num[NUM_W-1:QUO_W];

    hprm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    // Rate register, sum, count, held value and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate      <= RATE_RESET;
            r_prev_sq   <= '0;
            r_sum       <= '0;
            r_count     <= '0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_rate <= i_cfg_data;
            end
            if (ctl.ld_term) begin
                r_prev_sq <= prod;
            end
            // Saturate the running sum
            if (ctl.ld_sum) begin
                r_sum <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
            end
            // Window still open: advance the count, saturating
            if (ctl.chk_close && !sts.close && r_count != '1) begin
                r_count <= r_count + 1'b1;
            end
            if (ctl.fin) begin
                r_held  <= r_res[RMS_W-1:0];
                r_sum   <= '0;
                r_count <= CNT_W'(1);
            end
            if (ctl.emit) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mag  <= mag_in;
            r_freq <= i_freq_mhz;
        end
        if (ctl.ld_term) begin
            r_term <= prod + r_prev_sq;
        end
        if (ctl.ld_sum) begin
            r_limit <= prod[LIMIT_W-1:0];
        end
        if (ctl.chk_close) begin
            r_new <= sts.close;
        end
        // Assemble sum * freq from its two partial products
        if (ctl.ld_plo) begin
            r_num <= NUM_W'(prod[PART_W-1:0]);
        end
        if (ctl.ld_phi) begin
            r_num[NUM_W-1:QUO_W] <= num_hi_add;
        end
        // A quotient of 2^32 or more gives a root that saturates
        if (ctl.chk_sat) begin
            r_rem <= r_num[QUO_W+LIMIT_W-1:QUO_W];
            r_quo <= r_num[QUO_W-1:0];
            r_res <= sts.sat ? QUO_W'(RMS_MAX) : '0;
            r_bit <= SQRT_BIT0;
        end
        // Restoring division, one quotient bit per step
        if (ctl.div_step) begin
            r_rem <= csub_ge ? csub_diff[LIMIT_W-1:0]
                             : {r_rem[LIMIT_W-2:0], r_quo[QUO_W-1]};
            r_quo <= {r_quo[QUO_W-2:0], csub_ge};
        end
        // Digit-by-digit square root, one result bit per step
        if (ctl.sqrt_step) begin
            if (csub_ge) begin
                r_quo <= csub_diff[QUO_W-1:0];
                r_res <= (r_res >> 1) | r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (ctl.emit) begin
            r_out_rms <= r_held;
            r_out_new <= r_new;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_rms_value = r_out_rms;
    assign o_new_value = r_out_new;

endmodule

`default_nettype wire

// ===== rtl/core/hprm_checker.sv =====
// ----------------------------------------------------------------------------
// hprm_checker
// Port-level checks of the half-period RMS meter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "half_period_rms_meter_core_defines.svh"

module hprm_checker #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    input  wire logic                           o_in_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  wire logic [hprm_pkg::FREQ_W-1:0]    i_freq_mhz,
    input  wire logic                           o_out_valid,
    input  wire logic                           i_out_stall,
    input  wire logic [hprm_pkg::RMS_W-1:0]     o_rms_value,
    input  wire logic                           o_new_value,
    input  wire logic                           i_cfg_valid,
    input  wire logic                           o_cfg_ready,
    input  wire logic [hprm_pkg::RATE_W-1:0]    i_cfg_data
);
    import hprm_pkg::*;

    logic             in_acc;
    logic             out_acc;
    logic [1:0]       r_pend;
    logic [RMS_W-1:0] r_last_rms;
    logic             cfg_seen;

    assign in_acc   = i_in_valid & ~o_in_stall;
    assign out_acc  = o_out_valid & ~i_out_stall;
    assign cfg_seen = i_cfg_valid & o_cfg_ready & (i_cfg_data != '0) & (i_sample != '0)
                      & (i_freq_mhz != '0);

    // Track requests in flight and the last delivered value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend     <= '0;
            r_last_rms <= '0;
        end else begin
            r_pend <= r_pend + {1'b0, in_acc} - {1'b0, out_acc};
            if (out_acc) begin
                r_last_rms <= o_rms_value;
            end
        end
    end

    `HPRM_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_rms_value) && $stable(o_new_value), "stalled result changed")
    `HPRM_ASSERT_NXT(a_one_at_a_time, i_clk, i_rst_n, in_acc || (cfg_seen && 1'b0), o_in_stall, "request taken while busy")
    `HPRM_ASSERT_IMP(a_result_owed, i_clk, i_rst_n, 1'b1, r_pend != 2'd3 && (!o_out_valid || r_pend != 2'd0), "result without a request")
    `HPRM_ASSERT_IMP(a_value_kept, i_clk, i_rst_n, out_acc && !o_new_value, o_rms_value == r_last_rms, "value changed without a window")

endmodule

bind half_period_rms_meter_core hprm_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_hprm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_sample    (i_sample),
    .i_freq_mhz  (i_freq_mhz),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_rms_value (o_rms_value),
    .o_new_value (o_new_value),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .i_cfg_data  (i_cfg_data)
);

`default_nettype wire
